// File: src/bmhe_pkg.sv
package bmhe_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int IDX_W         = 6;
	localparam int COUNT_OUT_W   = 7;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_DELETE  = 2'd1,
		ACT_APPEND  = 2'd2,
		ACT_HEAPIFY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_NO_ENTRY = 2'd2
	} status_t;

	typedef struct packed {
		action_t              action;
		logic signed [31:0]   key;
		logic [IDX_W-1:0]     element_index;
	} request_t;

	typedef struct packed {
		logic signed [31:0]       removed_value;
		status_t                  status;
		logic [COUNT_OUT_W-1:0]   entry_count;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DEL_RD,
		ST_DEL_CHK,
		ST_DEL_UP_RD,
		ST_DEL_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_HEAP_RD,
		ST_HEAP_LD,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_FULL,
		OP_NOENT,
		OP_APPEND,
		OP_INSERT,
		OP_UP_RD,
		OP_UP_MOVE,
		OP_PLACE,
		OP_PLACE_NEXT,
		OP_DEL_RD,
		OP_DEL_TAKE,
		OP_DN_RD,
		OP_DN_MOVE,
		OP_HEAP_INIT,
		OP_HEAP_RD,
		OP_HEAP_LD
	} dp_op_t;

	typedef struct packed {
		action_t action;
		logic    full;
		logic    idx_bad;
		logic    idx_is_last;
		logic    idx_zero;
		logic    few;
		logic    pos_zero;
		logic    no_left;
		logic    up_less;
		logic    dn_more;
		logic    hi_zero;
	} dp_status_t;

endpackage

// File: src/binary_min_heap_engine_unit.sv
// Binary min-heap of signed keys held in an on-chip RAM of CAPACITY entries.
// Command channel: drive request and raise start; the transfer happens at the
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown. Actions: insert with sift up, delete at an index
// (index 0 extracts the minimum), append without ordering, and heapify.
// Result channel: done is high for exactly one cycle and result is valid in
// that cycle; it must be captured then, as the block cannot be held off.
// Each tree level walked costs a read state and a compare/write state, as the
// key RAM's read is registered. A delete of the last entry needs no sift, and
// append, refused actions and a heapify of fewer than two entries finish with
// no tree walk. Heapify sifts down each of the count/2 internal nodes in turn.
// One action is in flight at a time; the next start is taken in the cycle
// after done. Reset empties the heap at once (entry count zero); the RAM is
// not cleared, as only entries below the count are ever read.
module binary_min_heap_engine_unit #(
	parameter int CAPACITY  = bmhe_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = bmhe_pkg::KEY_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bmhe_pkg::request_t request,
	output logic               done,
	output bmhe_pkg::result_t  result
);

	bmhe_pkg::dp_op_t     op;
	bmhe_pkg::dp_status_t st;

	bmhe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	bmhe_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.op      (op),
		.st      (st),
		.result  (result)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while the engine is idle");

	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("result shown in the cycle after a command transfer");

	a_end_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("engine went idle without showing a result");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == bmhe_pkg::STATUS_NO_ENTRY ||
			result.status == bmhe_pkg::STATUS_FULL) |-> result.removed_value == '0)
		else $error("refused action returned a nonzero removed value");

endmodule

// File: src/bmhe_ram.sv
module bmhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: src/bmhe_ctrl.sv
module bmhe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  bmhe_pkg::dp_status_t  st,
	output bmhe_pkg::dp_op_t      op,
	output logic                  busy,
	output logic                  done
);

	bmhe_pkg::state_t state_q;
	bmhe_pkg::state_t state_nx;
	logic             heap_more;

	// Heapify walks on to the next internal node until index zero is placed.
	assign heap_more = (st.action == bmhe_pkg::ACT_HEAPIFY) && !st.hi_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			bmhe_pkg::ST_IDLE: begin
				if (start) state_nx = bmhe_pkg::ST_DECODE;
			end
			bmhe_pkg::ST_DECODE: begin
				case (st.action)
					bmhe_pkg::ACT_INSERT: begin
						state_nx = st.full ? bmhe_pkg::ST_DONE : bmhe_pkg::ST_UP_RD;
					end
					bmhe_pkg::ACT_APPEND: begin
						state_nx = bmhe_pkg::ST_DONE;
					end
					bmhe_pkg::ACT_DELETE: begin
						state_nx = st.idx_bad ? bmhe_pkg::ST_DONE : bmhe_pkg::ST_DEL_RD;
					end
					default: begin
						state_nx = st.few ? bmhe_pkg::ST_DONE : bmhe_pkg::ST_HEAP_RD;
					end
				endcase
			end
			bmhe_pkg::ST_UP_RD: begin
				state_nx = st.pos_zero ? bmhe_pkg::ST_DONE : bmhe_pkg::ST_UP_CMP;
			end
			bmhe_pkg::ST_UP_CMP: begin
				state_nx = st.up_less ? bmhe_pkg::ST_UP_RD : bmhe_pkg::ST_DONE;
			end
			bmhe_pkg::ST_DEL_RD: begin
				state_nx = bmhe_pkg::ST_DEL_CHK;
			end
			bmhe_pkg::ST_DEL_CHK: begin
				if (st.idx_is_last) begin
					state_nx = bmhe_pkg::ST_DONE;
				end else if (st.idx_zero) begin
					state_nx = bmhe_pkg::ST_DN_RD;
				end else begin
					state_nx = bmhe_pkg::ST_DEL_UP_RD;
				end
			end
			bmhe_pkg::ST_DEL_UP_RD: begin
				state_nx = bmhe_pkg::ST_DEL_UP_CMP;
			end
			bmhe_pkg::ST_DEL_UP_CMP: begin
				state_nx = st.up_less ? bmhe_pkg::ST_UP_RD : bmhe_pkg::ST_DN_RD;
			end
			bmhe_pkg::ST_DN_RD: begin
				if (!st.no_left) begin
					state_nx = bmhe_pkg::ST_DN_CMP;
				end else begin
					state_nx = heap_more ? bmhe_pkg::ST_HEAP_RD : bmhe_pkg::ST_DONE;
				end
			end
			bmhe_pkg::ST_DN_CMP: begin
				if (st.dn_more) begin
					state_nx = bmhe_pkg::ST_DN_RD;
				end else begin
					state_nx = heap_more ? bmhe_pkg::ST_HEAP_RD : bmhe_pkg::ST_DONE;
				end
			end
			bmhe_pkg::ST_HEAP_RD: begin
				state_nx = bmhe_pkg::ST_HEAP_LD;
			end
			bmhe_pkg::ST_HEAP_LD: begin
				state_nx = bmhe_pkg::ST_DN_RD;
			end
			bmhe_pkg::ST_DONE: begin
				state_nx = bmhe_pkg::ST_IDLE;
			end
			default: begin
				state_nx = bmhe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		op   = bmhe_pkg::OP_NONE;
		busy = (state_q != bmhe_pkg::ST_IDLE);
		done = (state_q == bmhe_pkg::ST_DONE);
		case (state_q)
			bmhe_pkg::ST_IDLE: begin
				if (start) op = bmhe_pkg::OP_LATCH;
			end
			bmhe_pkg::ST_DECODE: begin
				case (st.action)
					bmhe_pkg::ACT_INSERT: begin
						op = st.full ? bmhe_pkg::OP_FULL : bmhe_pkg::OP_INSERT;
					end
					bmhe_pkg::ACT_APPEND: begin
						op = st.full ? bmhe_pkg::OP_FULL : bmhe_pkg::OP_APPEND;
					end
					bmhe_pkg::ACT_DELETE: begin
						op = st.idx_bad ? bmhe_pkg::OP_NOENT : bmhe_pkg::OP_NONE;
					end
					default: begin
						op = st.few ? bmhe_pkg::OP_NONE : bmhe_pkg::OP_HEAP_INIT;
					end
				endcase
			end
			bmhe_pkg::ST_UP_RD: begin
				op = st.pos_zero ? bmhe_pkg::OP_PLACE : bmhe_pkg::OP_UP_RD;
			end
			bmhe_pkg::ST_UP_CMP: begin
				op = st.up_less ? bmhe_pkg::OP_UP_MOVE : bmhe_pkg::OP_PLACE;
			end
			bmhe_pkg::ST_DEL_RD: begin
				op = bmhe_pkg::OP_DEL_RD;
			end
			bmhe_pkg::ST_DEL_CHK: begin
				op = bmhe_pkg::OP_DEL_TAKE;
			end
			bmhe_pkg::ST_DEL_UP_RD: begin
				op = bmhe_pkg::OP_UP_RD;
			end
			bmhe_pkg::ST_DEL_UP_CMP: begin
				op = st.up_less ? bmhe_pkg::OP_UP_MOVE : bmhe_pkg::OP_NONE;
			end
			bmhe_pkg::ST_DN_RD: begin
				op = st.no_left ? bmhe_pkg::OP_PLACE_NEXT : bmhe_pkg::OP_DN_RD;
			end
			bmhe_pkg::ST_DN_CMP: begin
				op = st.dn_more ? bmhe_pkg::OP_DN_MOVE : bmhe_pkg::OP_PLACE_NEXT;
			end
			bmhe_pkg::ST_HEAP_RD: begin
				op = bmhe_pkg::OP_HEAP_RD;
			end
			bmhe_pkg::ST_HEAP_LD: begin
				op = bmhe_pkg::OP_HEAP_LD;
			end
			default: begin
				op = bmhe_pkg::OP_NONE;
			end
		endcase
	end

endmodule

// File: src/bmhe_dp.sv
module bmhe_dp #(
	parameter int CAPACITY  = bmhe_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = bmhe_pkg::KEY_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmhe_pkg::request_t    request,
	input  bmhe_pkg::dp_op_t      op,
	output bmhe_pkg::dp_status_t  st,
	output bmhe_pkg::result_t     result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NW = AW + 2;
	localparam int XW = (CW > bmhe_pkg::IDX_W) ? CW : bmhe_pkg::IDX_W;

	bmhe_pkg::request_t    in_q;
	logic [KEY_WIDTH-1:0]  k_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         hi_q;
	logic [CW-1:0]         count_q;
	logic signed [31:0]    removed_q;
	bmhe_pkg::status_t     status_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [KEY_WIDTH-1:0]  wdata;
	logic [AW-1:0]         raddr_a;
	logic [AW-1:0]         raddr_b;
	logic [KEY_WIDTH-1:0]  rd_a;
	logic [KEY_WIDTH-1:0]  rd_b;

	logic signed [KEY_WIDTH-1:0] enc_key;
	logic [AW-1:0]         parent;
	logic [NW-1:0]         left_n;
	logic [NW-1:0]         right_n;
	logic [NW-1:0]         count_n;
	logic [XW-1:0]         idx_x;
	logic [XW-1:0]         cnt_x;
	logic                  right_ok;
	logic                  pick_left;
	logic [KEY_WIDTH-1:0]  pick_val;

	// The incoming key is sign-extended or wrapped to the stored key width.
	assign enc_key = KEY_WIDTH'($signed(in_q.key));
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign left_n  = {1'b0, pos_q, 1'b1};
	assign right_n = left_n + NW'(1);
	assign count_n = NW'(count_q);
	assign idx_x   = XW'(in_q.element_index);
	assign cnt_x   = XW'(count_q);

	assign right_ok  = right_n < count_n;
	assign pick_left = !right_ok || ($signed(rd_a) < $signed(rd_b));
	assign pick_val  = pick_left ? rd_a : rd_b;

	always_comb begin
		st.action      = in_q.action;
		st.full        = (count_q >= CW'(CAPACITY));
		st.idx_bad     = (idx_x >= cnt_x);
		st.idx_is_last = ((idx_x + XW'(1)) == cnt_x);
		st.idx_zero    = (idx_x == '0);
		st.few         = (count_q < CW'(2));
		st.pos_zero    = (pos_q == '0);
		st.no_left     = (left_n >= count_n);
		st.up_less     = ($signed(k_q) < $signed(rd_a));
		st.dn_more     = ($signed(k_q) > $signed(pick_val));
		st.hi_zero     = (hi_q == '0);
	end

	// The moving key stays in k_q; only the hole it leaves is written back.
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = k_q;
		raddr_a = '0;
		raddr_b = '0;
		case (op)
			bmhe_pkg::OP_APPEND: begin
				we    = 1'b1;
				waddr = AW'(count_q);
				wdata = enc_key;
			end
			bmhe_pkg::OP_UP_RD: begin
				raddr_a = parent;
			end
			bmhe_pkg::OP_UP_MOVE: begin
				we    = 1'b1;
				wdata = rd_a;
			end
			bmhe_pkg::OP_PLACE, bmhe_pkg::OP_PLACE_NEXT: begin
				we = 1'b1;
			end
			bmhe_pkg::OP_DEL_RD: begin
				raddr_a = AW'(in_q.element_index);
				raddr_b = AW'(count_q - CW'(1));
			end
			bmhe_pkg::OP_DN_RD: begin
				raddr_a = left_n[AW-1:0];
				raddr_b = right_n[AW-1:0];
			end
			bmhe_pkg::OP_DN_MOVE: begin
				we    = 1'b1;
				wdata = pick_val;
			end
			bmhe_pkg::OP_HEAP_RD: begin
				raddr_a = hi_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				bmhe_pkg::OP_APPEND, bmhe_pkg::OP_INSERT: begin
					count_q <= count_q + CW'(1);
				end
				bmhe_pkg::OP_DEL_TAKE: begin
					count_q <= count_q - CW'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			bmhe_pkg::OP_LATCH: begin
				in_q      <= request;
				removed_q <= '0;
				status_q  <= bmhe_pkg::STATUS_OK;
			end
			bmhe_pkg::OP_FULL: begin
				status_q <= bmhe_pkg::STATUS_FULL;
			end
			bmhe_pkg::OP_NOENT: begin
				status_q <= bmhe_pkg::STATUS_NO_ENTRY;
			end
			bmhe_pkg::OP_INSERT: begin
				k_q   <= enc_key;
				pos_q <= AW'(count_q);
			end
			bmhe_pkg::OP_UP_MOVE: begin
				pos_q <= parent;
			end
			bmhe_pkg::OP_DEL_TAKE: begin
				removed_q <= 32'($signed(rd_a));
				k_q       <= rd_b;
				pos_q     <= AW'(in_q.element_index);
			end
			bmhe_pkg::OP_DN_MOVE: begin
				pos_q <= pick_left ? left_n[AW-1:0] : right_n[AW-1:0];
			end
			bmhe_pkg::OP_HEAP_INIT: begin
				hi_q <= AW'((count_q >> 1) - CW'(1));
			end
			bmhe_pkg::OP_HEAP_LD: begin
				k_q   <= rd_a;
				pos_q <= hi_q;
			end
			bmhe_pkg::OP_PLACE_NEXT: begin
				hi_q <= hi_q - AW'(1);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	bmhe_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	assign result.removed_value = removed_q;
	assign result.status        = status_q;
	assign result.entry_count   = bmhe_pkg::COUNT_OUT_W'(count_q);

endmodule
